/* src/wtms_pkg.sv */
// Shared constants and command codes for the min winner tree.
`default_nettype none
package wtms_pkg;
  localparam int MAX_LEAVES_DEF = 64;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam logic signed [VALUE_W-1:0] LEAF_INF = 32'sh7FFF_FFFF;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DELETE = 1'b1;
endpackage
`default_nettype wire

/* src/wtms_in_if.sv */
// Input channel: command word with leaf value and last flag.
`default_nettype none
interface wtms_in_if import wtms_pkg::*;;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [VALUE_W-1:0] value;
  logic last;
  modport source (output valid, output cmd, output value, output last, input ready);
  modport sink (input valid, input cmd, input value, input last, output ready);
endinterface
`default_nettype wire

/* src/wtms_out_if.sv */
// Output channel: current minimum value and its leaf index.
`default_nettype none
interface wtms_out_if import wtms_pkg::*;;
  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] min_value;
  logic [INDEX_W-1:0] min_index;
  modport source (output valid, output min_value, output min_index, input ready);
  modport sink (input valid, input min_value, input min_index, output ready);
endinterface
`default_nettype wire

/* src/winner_tree_min_select_core.sv */
// Top level: min winner tree with a match sequencer over shared memories.
//
//  channel | role   | word contents                | accepted when
//  --------+--------+------------------------------+---------------------
//  req     | sink   | cmd, value, last             | req.valid & req.ready
//  rsp     | source | min_value, min_index         | rsp.valid & rsp.ready
//
// A load word without last leaves req ready for the next word. A last
// load builds the tree with one match per internal node, in S_NODE
// (winner read), S_LEAF (leaf read) and S_CMP (compare and write). A
// delete retires the winner's leaf, then replays one match per level of
// its path. One match unit and one winner write port serialize the matches.
// Reset clears the counters and flags only; the memories need no clearing,
// since every entry is written before it is read. A stalled rsp holds its
// word while req stays open; a new result waits in the report state.
`default_nettype none
module winner_tree_min_select_core import wtms_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  wtms_in_if.sink   req,
  wtms_out_if.source rsp
);
  localparam int IDX_W = $clog2(MAX_LEAVES);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DEL, S_NODE, S_LEAF, S_CMP, S_ROOT, S_RLEAF, S_REP
  } state_t;

  state_t state;
  logic             tree_ready;
  logic             mode_build;
  logic [CNT_W-1:0] leaf_count;
  logic [CNT_W-1:0] load_pointer;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] a_reg;
  logic [IDX_W-1:0] b_reg;
  logic [IDX_W-1:0] w_reg;
  logic             out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [INDEX_W-1:0]        out_index;

  // memory ports
  logic                      leaf_we;
  logic [IDX_W-1:0]          leaf_waddr;
  logic signed [VALUE_W-1:0] leaf_wdata;
  logic [IDX_W-1:0]          leaf_raddr_a;
  logic [IDX_W-1:0]          leaf_raddr_b;
  logic signed [VALUE_W-1:0] leaf_rdata_a;
  logic signed [VALUE_W-1:0] leaf_rdata_b;
  logic                      wn_we;
  logic [IDX_W-1:0]          wn_raddr_a;
  logic [IDX_W-1:0]          wn_raddr_b;
  logic [IDX_W-1:0]          wn_rdata_a;
  logic [IDX_W-1:0]          wn_rdata_b;
  logic [IDX_W-1:0]          win;

  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_new;
  logic [CNT_W-1:0] c0;
  logic [CNT_W-1:0] c1;
  logic [CNT_W-1:0] c0_leaf;
  logic [CNT_W-1:0] c1_leaf;
  logic [IDX_W-1:0] a_comb;
  logic [IDX_W-1:0] b_comb;
  logic [IDX_W-1:0] w_comb;
  logic [CNT_W-1:0] path_sum;
  logic [IDX_W-1:0] k_half;

  assign req.ready     = (state == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.min_value = out_value;
  assign rsp.min_index = out_index;

  assign room      = (load_pointer < CNT_W'(MAX_LEAVES));
  assign count_new = room ? load_pointer + CNT_W'(1) : load_pointer;

  // children of node k: below leaf_count they are internal, else leaves
  assign c0      = {k, 1'b0};
  assign c1      = {k, 1'b1};
  assign c0_leaf = c0 - leaf_count;
  assign c1_leaf = c1 - leaf_count;
  assign a_comb  = (c0 >= leaf_count) ? c0_leaf[IDX_W-1:0] : wn_rdata_a;
  assign b_comb  = (c1 >= leaf_count) ? c1_leaf[IDX_W-1:0] : wn_rdata_b;

  // root winner, valid where the previous cycle read winner node 1
  assign w_comb   = (leaf_count <= CNT_W'(1)) ? '0 : wn_rdata_a;
  assign path_sum = CNT_W'(w_comb) + leaf_count;
  assign k_half   = k >> 1;

  always_comb begin
    wn_raddr_a   = IDX_W'(1);
    wn_raddr_b   = c1[IDX_W-1:0];
    leaf_raddr_a = w_reg;
    leaf_raddr_b = b_comb;
    leaf_we      = 1'b0;
    leaf_waddr   = load_pointer[IDX_W-1:0];
    leaf_wdata   = req.value;
    wn_we        = 1'b0;
    unique case (state)
      S_IDLE: begin
        leaf_we = accept && (req.cmd == CMD_LOAD) && room;
      end
      S_DEL: begin
        leaf_we    = 1'b1;
        leaf_waddr = w_comb;
        leaf_wdata = LEAF_INF;
      end
      S_NODE: begin
        wn_raddr_a = c0[IDX_W-1:0];
        wn_raddr_b = c1[IDX_W-1:0];
      end
      S_LEAF: begin
        leaf_raddr_a = a_comb;
        leaf_raddr_b = b_comb;
      end
      S_CMP: begin
        wn_we = 1'b1;
      end
      S_ROOT: begin
      end
      S_RLEAF: begin
        leaf_raddr_a = w_comb;
      end
      S_REP: begin
      end
      default: begin
      end
    endcase
  end

  wtms_store #(.MAX_LEAVES(MAX_LEAVES), .IDX_W(IDX_W)) u_store (
    .clk          (clk),
    .leaf_we      (leaf_we),
    .leaf_waddr   (leaf_waddr),
    .leaf_wdata   (leaf_wdata),
    .leaf_raddr_a (leaf_raddr_a),
    .leaf_raddr_b (leaf_raddr_b),
    .leaf_rdata_a (leaf_rdata_a),
    .leaf_rdata_b (leaf_rdata_b),
    .wn_we        (wn_we),
    .wn_waddr     (k),
    .wn_wdata     (win),
    .wn_raddr_a   (wn_raddr_a),
    .wn_raddr_b   (wn_raddr_b),
    .wn_rdata_a   (wn_rdata_a),
    .wn_rdata_b   (wn_rdata_b)
  );

  wtms_match #(.IDX_W(IDX_W)) u_match (
    .idx_a (a_reg),
    .idx_b (b_reg),
    .val_a (leaf_rdata_a),
    .val_b (leaf_rdata_b),
    .win   (win)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tree_ready   <= 1'b0;
      leaf_count   <= '0;
      load_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      // drop the output word once taken, unless the report state refills it
      if (out_valid && rsp.ready && (state != S_REP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.cmd == CMD_LOAD) begin
              tree_ready   <= 1'b0;
              load_pointer <= req.last ? '0 : count_new;
              if (req.last) begin
                leaf_count   <= count_new;
                mode_build   <= 1'b1;
                k            <= IDX_W'(count_new - CNT_W'(1));
                state        <= (count_new > CNT_W'(1)) ? S_NODE : S_ROOT;
              end
            end else if (tree_ready) begin
              state <= S_DEL;
            end
          end
        end
        S_DEL: begin
          // retire the winner's leaf, then replay its path upward
          mode_build <= 1'b0;
          k          <= path_sum[CNT_W-1:1];
          state      <= (path_sum[CNT_W-1:1] == '0) ? S_ROOT : S_NODE;
        end
        S_NODE: begin
          state <= S_LEAF;
        end
        S_LEAF: begin
          a_reg <= a_comb;
          b_reg <= b_comb;
          state <= S_CMP;
        end
        S_CMP: begin
          if (mode_build) begin
            if (k == IDX_W'(1)) begin
              state <= S_ROOT;
            end else begin
              k     <= k - IDX_W'(1);
              state <= S_NODE;
            end
          end else begin
            k     <= k_half;
            state <= (k_half == '0) ? S_ROOT : S_NODE;
          end
        end
        S_ROOT: begin
          state <= S_RLEAF;
        end
        S_RLEAF: begin
          w_reg <= w_comb;
          state <= S_REP;
        end
        S_REP: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= leaf_rdata_a;
            out_index  <= INDEX_W'(w_reg);
            tree_ready <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/wtms_match.sv */
// Shared match unit: signed compare of two leaves, ties to the left.
`default_nettype none
module wtms_match import wtms_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  wire logic [IDX_W-1:0]          idx_a,
  input  wire logic [IDX_W-1:0]          idx_b,
  input  wire logic signed [VALUE_W-1:0] val_a,
  input  wire logic signed [VALUE_W-1:0] val_b,
  output logic [IDX_W-1:0]               win
);
  assign win = (val_a <= val_b) ? idx_a : idx_b;
endmodule
`default_nettype wire

/* src/wtms_store.sv */
// Leaf value memory and winner index memory, two registered read ports each.
`default_nettype none
module wtms_store import wtms_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF,
  parameter int IDX_W = $clog2(MAX_LEAVES)
) (
  input  wire logic                      clk,
  input  wire logic                      leaf_we,
  input  wire logic [IDX_W-1:0]          leaf_waddr,
  input  wire logic signed [VALUE_W-1:0] leaf_wdata,
  input  wire logic [IDX_W-1:0]          leaf_raddr_a,
  input  wire logic [IDX_W-1:0]          leaf_raddr_b,
  output logic signed [VALUE_W-1:0]      leaf_rdata_a,
  output logic signed [VALUE_W-1:0]      leaf_rdata_b,
  input  wire logic                      wn_we,
  input  wire logic [IDX_W-1:0]          wn_waddr,
  input  wire logic [IDX_W-1:0]          wn_wdata,
  input  wire logic [IDX_W-1:0]          wn_raddr_a,
  input  wire logic [IDX_W-1:0]          wn_raddr_b,
  output logic [IDX_W-1:0]               wn_rdata_a,
  output logic [IDX_W-1:0]               wn_rdata_b
);
  logic signed [VALUE_W-1:0] leaf_mem [MAX_LEAVES];
  logic [IDX_W-1:0]          wn_mem [MAX_LEAVES];

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rdata_a <= leaf_mem[leaf_raddr_a];
    leaf_rdata_b <= leaf_mem[leaf_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (wn_we) begin
      wn_mem[wn_waddr] <= wn_wdata;
    end
    wn_rdata_a <= wn_mem[wn_raddr_a];
    wn_rdata_b <= wn_mem[wn_raddr_b];
  end
endmodule
`default_nettype wire

/* src/wtms_checker.sv */
// Port-level checks for the min winner tree, bound to the top level.
`default_nettype none
module wtms_bind_checker import wtms_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire logic                      req_cmd,
  input wire logic                      req_last,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic signed [VALUE_W-1:0] rsp_min_value,
  input wire logic [INDEX_W-1:0]        rsp_min_index
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_min_value) && $stable(rsp_min_index))
    else $error("rsp word changed while stalled");

  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_LOAD && req_last |=> !req_ready)
    else $error("ready during tree build");

  a_load_open: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_LOAD && !req_last |=> req_ready)
    else $error("plain load word did not complete in one cycle");
endmodule

bind winner_tree_min_select_core wtms_bind_checker u_wtms_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_cmd       (req.cmd),
  .req_last      (req.last),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_min_value (rsp.min_value),
  .rsp_min_index (rsp.min_index)
);
`default_nettype wire
